>>> rtl/ptv_pkg.sv
// shared constants, types and the wildcard rule check for the topic validator
`timescale 1ns / 1ps

package ptv_pkg;

  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_NONE      = 8'h00;
  localparam logic [7:0] MAX_LEN_RST  = 8'd64;
  localparam int         CountW       = 9;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  localparam logic KIND_PUBLISH   = 1'b0;
  localparam logic KIND_SUBSCRIBE = 1'b1;

  localparam logic STATUS_VALID   = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic       status;
    logic [7:0] stripped_length;
  } ptv_result_t;

  // cur is the byte under check, prv the kept byte before it, nxt the byte after it
  // (zero stands for start or end of topic)
  function automatic logic wildcard_bad(input logic kind, input logic [7:0] prv,
                                        input logic [7:0] cur, input logic [7:0] nxt);
    logic prev_ok;
    logic bad;
    prev_ok = (prv == CH_NONE) || (prv == CH_SLASH);
    bad = 1'b0;
    if (kind == KIND_PUBLISH) begin
      bad = (cur == CH_PLUS) || (cur == CH_HASH);
    end else if (cur == CH_PLUS) begin
      bad = !prev_ok || !((nxt == CH_NONE) || (nxt == CH_SLASH));
    end else if (cur == CH_HASH) begin
      bad = !prev_ok || (nxt != CH_NONE);
    end
    return bad;
  endfunction

endpackage

>>> rtl/ptv_track.sv
// per-topic tracking state and the single-pass byte check
`timescale 1ns / 1ps

module ptv_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 max_length_we,
  input  logic [7:0]           max_length_wdata,
  input  logic                 step,
  input  logic                 kind,
  input  logic [7:0]           symbol,
  input  logic                 is_final,
  output ptv_pkg::ptv_result_t result
);
  import ptv_pkg::*;

  logic [7:0]        max_length;
  logic [CountW-1:0] byte_count;
  logic              bad_flag;
  logic [7:0]        held_byte;
  logic [7:0]        byte_before_held;
  logic              held_valid;
  logic              lead_cut;

  logic [CountW-1:0] byte_count_next;
  logic              bad_flag_next;
  logic [7:0]        held_byte_next;
  logic [7:0]        byte_before_held_next;
  logic              held_valid_next;
  logic              lead_cut_next;
  logic              lead;
  logic              tail;
  logic              keep;
  logic              bad_final;
  logic [CountW-1:0] len;

  always_comb begin
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;
    lead = (byte_count == '0) && (symbol == CH_SLASH);
    tail = !lead && is_final && (symbol == CH_SLASH);
    keep = !lead && !tail;

    bad_flag_next = bad_flag
                  || (byte_count_next > {1'b0, max_length})
                  || (symbol == CH_NONE) || symbol[7];
    if (keep && held_valid) begin
      bad_flag_next = bad_flag_next || wildcard_bad(kind, byte_before_held, held_byte, symbol);
    end

    byte_before_held_next = byte_before_held;
    held_byte_next        = held_byte;
    if (keep) begin
      byte_before_held_next = held_valid ? held_byte : CH_NONE;
      held_byte_next        = symbol;
    end
    held_valid_next = held_valid || keep;
    lead_cut_next   = lead_cut || lead;

    // last kept byte is checked against the end of topic
    bad_final = held_valid_next
              ? (bad_flag_next ||
                 wildcard_bad(kind, byte_before_held_next, held_byte_next, CH_NONE))
              : 1'b1;

    len = byte_count_next - CountW'(lead_cut_next) - CountW'(tail);
    result.status          = bad_final ? STATUS_INVALID : STATUS_VALID;
    result.stripped_length = (len > CountW'(255)) ? 8'hFF : len[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LEN_RST;
    end else if (max_length_we) begin
      max_length <= max_length_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      bad_flag         <= 1'b0;
      held_byte        <= CH_NONE;
      byte_before_held <= CH_NONE;
      held_valid       <= 1'b0;
      lead_cut         <= 1'b0;
    end else if (step) begin
      if (is_final) begin
        // topic done, back to start
        byte_count       <= '0;
        bad_flag         <= 1'b0;
        held_byte        <= CH_NONE;
        byte_before_held <= CH_NONE;
        held_valid       <= 1'b0;
        lead_cut         <= 1'b0;
      end else begin
        byte_count       <= byte_count_next;
        bad_flag         <= bad_flag_next;
        held_byte        <= held_byte_next;
        byte_before_held <= byte_before_held_next;
        held_valid       <= held_valid_next;
        lead_cut         <= lead_cut_next;
      end
    end
  end

endmodule

>>> rtl/pubsub_topic_validator_unit.sv
// Publish/subscribe topic validator, one topic byte per transfer.
// Input channel: kind, symbol, is_final with in_valid / in_stall. A topic is a
//   run of byte transfers ending in one with is_final set.
// Output channel: status (0 valid, 1 invalid) and stripped_length with
//   out_valid / out_stall, one result transfer per topic.
// Configuration: max_length_we / max_length_wdata write max_length (reset 64);
//   write only while no topic is in progress and no result is pending.
// Throughput: one byte per cycle unless a final byte is held back (see Stall);
//   a byte is registered, then checked against the held previous byte in a
//   single pass into the result register. The final byte is registered, then
//   its result goes into the output register, where it is offered.
// Stall: a waiting result holds a later final byte in s1 and with it the input;
//   non-final bytes keep flowing while the result register holds.
// Reset (rst, synchronous): clears the topic state and both channels' valid
//   flags, and sets max_length back to 64.
`timescale 1ns / 1ps

module pubsub_topic_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       max_length_we,
  input  logic [7:0] max_length_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] symbol,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       status,
  output logic [7:0] stripped_length
);
  import ptv_pkg::*;

  logic        s1_valid;
  logic        s1_kind;
  logic [7:0]  s1_symbol;
  logic        s1_final;
  logic        slot_free;
  logic        s1_adv;
  ptv_result_t result;
  ptv_result_t out_data;

  assign slot_free = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && (!s1_final || slot_free);
  assign in_stall  = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind   <= kind;
      s1_symbol <= symbol;
      s1_final  <= is_final;
    end
  end

  ptv_track u_track (
    .clk              (clk),
    .rst              (rst),
    .max_length_we    (max_length_we),
    .max_length_wdata (max_length_wdata),
    .step             (s1_adv),
    .kind             (s1_kind),
    .symbol           (s1_symbol),
    .is_final         (s1_final),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= s1_adv && s1_final;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && s1_adv && s1_final) begin
      out_data <= result;
    end
  end

  assign status          = out_data.status;
  assign stripped_length = out_data.stripped_length;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_final))
    else $error("input stalled without a pending final byte");

  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_final) |=> out_valid)
    else $error("final byte processed but no result offered");

  a_nonfinal_flows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_final) |-> !in_stall)
    else $error("non-final byte held back");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("valid flags not cleared by reset");

endmodule
